// ===== hw/rtl/mxpro_pkg.sv =====
package mxpro_pkg;

  // Set size and derived widths
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Field widths
  localparam int PREF_W = 16;
  localparam int SEED_W = 32;
  localparam int POS_W  = 4;
  localparam int ENT_W  = PREF_W + POS_W;

  // Generator constants
  localparam logic [SEED_W-1:0] LCG_MUL    = 32'd69069;
  localparam logic [SEED_W-1:0] LCG_ADD    = 32'd1;
  localparam logic [30:0]       HALF_RANGE = 31'h7FFF_FFFF;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_HEAD,
    ST_SCAN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // store the accepted item while the set is not full
    logic start;  // read the first entry
    logic head;   // take the first entry as best, read the second
    logic scan;   // compare the entry read, read the next
    logic fetch;  // read the final stored entry
    logic emit;   // hand out the best entry, move the final entry into its slot
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_scan;  // the entry being compared is the final one
    logic single;     // one entry left
    logic out_free;   // output register can take a result
  } stat_t;

  // One step of the linear congruential generator
  function automatic logic [SEED_W-1:0] lcg_next(input logic [SEED_W-1:0] r);
    logic [SEED_W-1:0] prod;
    prod = r * LCG_MUL;
    return prod + LCG_ADD;
  endfunction

endpackage

// ===== hw/rtl/mxpro_in_if.sv =====
interface mxpro_in_if;
  logic                          valid;
  logic                          ready;
  logic [mxpro_pkg::PREF_W-1:0]  preference;
  logic [mxpro_pkg::SEED_W-1:0]  seed;
  logic                          is_last;

  modport source (output valid, output preference, output seed, output is_last,
                  input ready);
  modport sink   (input valid, input preference, input seed, input is_last,
                  output ready);
endinterface

// ===== hw/rtl/mxpro_out_if.sv =====
interface mxpro_out_if;
  logic                          valid;
  logic                          ready;
  logic [mxpro_pkg::POS_W-1:0]   entry_index;
  logic [mxpro_pkg::PREF_W-1:0]  entry_preference;
  logic                          last_of_run;

  modport source (output valid, output entry_index, output entry_preference,
                  output last_of_run, input ready);
  modport sink   (input valid, input entry_index, input entry_preference,
                  input last_of_run, output ready);
endinterface

// ===== hw/rtl/mxpro_ram.sv =====
module mxpro_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mxpro_ctrl.sv =====
module mxpro_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  mxpro_pkg::stat_t stat,
  output mxpro_pkg::cmd_t  cmd
);

  mxpro_pkg::state_t state;
  mxpro_pkg::state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mxpro_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      mxpro_pkg::ST_IDLE: begin
        if (in_valid && in_last) begin
          state_next = mxpro_pkg::ST_START;
        end
      end
      mxpro_pkg::ST_START: begin
        state_next = mxpro_pkg::ST_HEAD;
      end
      mxpro_pkg::ST_HEAD: begin
        state_next = stat.single ? mxpro_pkg::ST_FETCH : mxpro_pkg::ST_SCAN;
      end
      mxpro_pkg::ST_SCAN: begin
        if (stat.last_scan) begin
          state_next = mxpro_pkg::ST_FETCH;
        end
      end
      mxpro_pkg::ST_FETCH: begin
        state_next = mxpro_pkg::ST_EMIT;
      end
      mxpro_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          state_next = stat.single ? mxpro_pkg::ST_IDLE : mxpro_pkg::ST_START;
        end
      end
      default: begin
        state_next = mxpro_pkg::ST_IDLE;
      end
    endcase
  end

  // Drive the datapath commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      mxpro_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mxpro_pkg::ST_START: begin
        cmd.start = 1'b1;
      end
      mxpro_pkg::ST_HEAD: begin
        cmd.head = 1'b1;
      end
      mxpro_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      mxpro_pkg::ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      mxpro_pkg::ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/mxpro_dp.sv =====
module mxpro_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  mxpro_pkg::cmd_t               cmd,
  output mxpro_pkg::stat_t              stat,
  input  logic [mxpro_pkg::PREF_W-1:0]  preference,
  input  logic [mxpro_pkg::SEED_W-1:0]  seed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mxpro_pkg::POS_W-1:0]   out_index,
  output logic [mxpro_pkg::PREF_W-1:0]  out_preference,
  output logic                          out_last
);

  localparam int IDX_W  = mxpro_pkg::IDX_W;
  localparam int CNT_W  = mxpro_pkg::CNT_W;
  localparam int PREF_W = mxpro_pkg::PREF_W;
  localparam int POS_W  = mxpro_pkg::POS_W;
  localparam int ENT_W  = mxpro_pkg::ENT_W;
  localparam int SEED_W = mxpro_pkg::SEED_W;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_m1;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  best_idx;
  logic [PREF_W-1:0] best_pref;
  logic [POS_W-1:0]  best_pos;
  logic [CNT_W-1:0]  same;
  logic [SEED_W-1:0] rnd_ahead;
  logic [SEED_W-1:0] lcg_in;
  logic [SEED_W-1:0] rnd_step;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENT_W-1:0]  rd_data;

  logic [PREF_W-1:0] cur_pref;
  logic [POS_W-1:0]  cur_pos;
  logic              is_less;
  logic              is_equal;
  logic              take_tie;
  logic              not_full;

  logic [30:0]       quot_tab [mxpro_pkg::MAX_ENTRIES];

  // Quotient table: entry k holds the tie threshold for a tie count of k + 1
  for (genvar g = 0; g < mxpro_pkg::MAX_ENTRIES; g++) begin : g_quot
    localparam logic [30:0] QV = 31'(mxpro_pkg::HALF_RANGE / (g + 1));
    assign quot_tab[g] = QV;
  end

  // Entry store: preference above load position
  mxpro_ram #(
    .WIDTH (ENT_W),
    .DEPTH (mxpro_pkg::MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign count_m1 = count - 1'b1;
  assign not_full = count < CNT_W'(mxpro_pkg::MAX_ENTRIES);
  assign cur_pref = rd_data[ENT_W-1:POS_W];
  assign cur_pos  = rd_data[POS_W-1:0];
  assign is_less  = cur_pref < best_pref;
  assign is_equal = cur_pref == best_pref;
  assign take_tie = rnd_ahead[SEED_W-1:1] < quot_tab[same[IDX_W-1:0]];

  // Generator: one multiplier, fed by the seed on a load or by the state on a tie
  assign lcg_in   = cmd.load ? seed : rnd_ahead;
  assign rnd_step = mxpro_pkg::lcg_next(lcg_in);

  // Store write port: load new entries, move the final entry on emit
  always_comb begin
    ram_we    = (cmd.load && not_full) || cmd.emit;
    ram_waddr = cmd.emit ? best_idx : count[IDX_W-1:0];
    ram_wdata = cmd.emit ? rd_data : {preference, POS_W'(count)};
  end

  // Store read port
  always_comb begin
    ram_re    = cmd.start || cmd.head || cmd.scan || cmd.fetch;
    ram_raddr = '0;
    if (cmd.head) begin
      ram_raddr = IDX_W'(1);
    end else if (cmd.scan) begin
      ram_raddr = j + 1'b1;
    end else if (cmd.fetch) begin
      ram_raddr = count_m1[IDX_W-1:0];
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load && not_full) begin
      count <= count + 1'b1;
    end else if (cmd.emit) begin
      count <= count_m1;
    end
  end

  // Generator state, one step ahead of the value last used
  always_ff @(posedge clk) begin
    if (cmd.load && (count == '0)) begin
      rnd_ahead <= rnd_step;
    end else if (cmd.scan && !is_less && is_equal) begin
      rnd_ahead <= rnd_step;
    end
  end

  // Scan for the lowest preference, sampling among ties
  always_ff @(posedge clk) begin
    if (cmd.head) begin
      best_pref <= cur_pref;
      best_pos  <= cur_pos;
      best_idx  <= '0;
      same      <= CNT_W'(1);
      j         <= IDX_W'(1);
    end else if (cmd.scan) begin
      j <= j + 1'b1;
      if (is_less) begin
        best_pref <= cur_pref;
        best_pos  <= cur_pos;
        best_idx  <= j;
        same      <= CNT_W'(1);
      end else if (is_equal) begin
        same <= same + 1'b1;
        if (take_tie) begin
          best_pref <= cur_pref;
          best_pos  <= cur_pos;
          best_idx  <= j;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index      <= best_pos;
      out_preference <= best_pref;
      out_last       <= stat.single;
    end
  end

  // Status back to the controller
  always_comb begin
    stat.last_scan = j == count_m1[IDX_W-1:0];
    stat.single    = count == CNT_W'(1);
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

// ===== hw/rtl/mx_preference_random_order.sv =====
// Loading: one item per cycle, no result for an item that is not marked last.
// Selection: with n entries left, a result takes a read, the first entry, n - 1
// compares, a fetch of the final entry and a transfer, which waits while the
// output register is full. The entry store has a single read port.
// Reset (rst, synchronous, active high) empties the set and the output
// register; the entry store itself is not cleared.
module mx_preference_random_order (
  input  logic         clk,
  input  logic         rst,
  mxpro_in_if.sink     entry_in,
  mxpro_out_if.source  entry_out
);

  mxpro_pkg::cmd_t  cmd;
  mxpro_pkg::stat_t stat;

  // Sequencer
  mxpro_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (entry_in.valid),
    .in_last  (entry_in.is_last),
    .in_ready (entry_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, scan and output register
  mxpro_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .preference     (entry_in.preference),
    .seed           (entry_in.seed),
    .out_valid      (entry_out.valid),
    .out_ready      (entry_out.ready),
    .out_index      (entry_out.entry_index),
    .out_preference (entry_out.entry_preference),
    .out_last       (entry_out.last_of_run)
  );

`ifndef SYNTHESIS
  // At most one datapath command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.start, cmd.head, cmd.scan, cmd.fetch, cmd.emit}))
    else $error("more than one datapath command");

  // A final item starts selection in the next cycle
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (entry_in.valid && entry_in.ready && entry_in.is_last) |=> cmd.start)
    else $error("selection did not start after the final item");

  // The final result of a set returns the block to loading
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && stat.single) |=> (entry_in.ready && entry_out.valid
                                   && entry_out.last_of_run))
    else $error("set did not close after its final result");

  // No new item is taken while selection runs
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.start || cmd.head || cmd.scan || cmd.fetch) |-> !entry_in.ready)
    else $error("input ready during selection");
`endif

endmodule
